/* rtl/core/tkc_pkg.sv */
// Shared constants, types, microcode program and coefficient table of the type K converter.
package tkc_pkg;

  localparam int AccFracBits = 40;
  localparam int RomFracBits = 48;
  localparam int RomShift    = RomFracBits - AccFracBits;
  localparam int OutShift    = AccFracBits - 16;
  localparam int XFracBits   = 16;

  localparam int EmfW   = 23;
  localparam int TempW  = 28;
  localparam int AccW   = 64;
  localparam int HalfW  = AccW / 2;
  localparam int ProdW  = HalfW + EmfW;
  localparam int MagW   = 62;

  localparam logic signed [EmfW-1:0] HighBandStart = 23'sd1352926;
  localparam logic signed [EmfW-1:0] HighBandMax   = 23'sd3597926;

  typedef logic [4:0] coef_addr_t;
  typedef logic [2:0] step_t;

  localparam coef_addr_t LowTop   = 5'd9;
  localparam coef_addr_t LowBase  = 5'd0;
  localparam coef_addr_t HighTop  = 5'd16;
  localparam coef_addr_t HighBase = 5'd10;

  localparam logic signed [AccW-1:0] RomHalf =
      (RomShift == 0) ? '0 : (64'sd1 <<< ((RomShift == 0) ? 0 : RomShift - 1));
  localparam logic signed [AccW-1:0] OutHalf = 64'sd1 <<< (OutShift - 1);

  typedef enum logic [2:0] {
    OpWait,
    OpNop,
    OpLoad,
    OpMul,
    OpMac,
    OpOut
  } op_e;

  typedef enum logic [2:0] {
    CondNone,
    CondIdle,
    CondOutRange,
    CondMore,
    CondOutBusy
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t jump;
    step_t next;
  } uword_t;

  localparam step_t StepWait  = 3'd0;
  localparam step_t StepCheck = 3'd1;
  localparam step_t StepLoad  = 3'd2;
  localparam step_t StepMul   = 3'd3;
  localparam step_t StepMac   = 3'd4;
  localparam step_t StepOut   = 3'd5;

  // The program: a taken condition goes to jump, otherwise to next.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      StepWait:  w = '{op: OpWait, cond: CondIdle,     jump: StepWait, next: StepCheck};
      StepCheck: w = '{op: OpNop,  cond: CondOutRange, jump: StepOut,  next: StepLoad};
      StepLoad:  w = '{op: OpLoad, cond: CondNone,     jump: StepWait, next: StepMul};
      StepMul:   w = '{op: OpMul,  cond: CondNone,     jump: StepWait, next: StepMac};
      StepMac:   w = '{op: OpMac,  cond: CondMore,     jump: StepMul,  next: StepOut};
      StepOut:   w = '{op: OpOut,  cond: CondOutBusy,  jump: StepOut,  next: StepWait};
      default:   w = '{op: OpNop,  cond: CondNone,     jump: StepWait, next: StepWait};
    endcase
    return w;
  endfunction

  // Low band coefficients d0..d9 sit at 0..9, high band e0..e6 at 10..16.
  function automatic logic signed [AccW-1:0] coef_acc(coef_addr_t a);
    logic signed [AccW-1:0] c;
    case (a)
      5'd0:    c = 64'sd0;
      5'd1:    c = 64'sd7060391652070575;
      5'd2:    c = 64'sd22124231532933;
      5'd3:    c = -64'sd70456873992872;
      5'd4:    c = 64'sd23405404295928;
      5'd5:    c = -64'sd3456608415499;
      5'd6:    c = 64'sd275959080477;
      5'd7:    c = -64'sd12421575165;
      5'd8:    c = 64'sd297725653;
      5'd9:    c = -64'sd2963242;
      5'd10:   c = -64'sd37100034485329383;
      5'd11:   c = 64'sd13595866249572982;
      5'd12:   c = -64'sd463316537390018;
      5'd13:   c = 64'sd15381850309550;
      5'd14:   c = -64'sd271643477987;
      5'd15:   c = 64'sd2477597070;
      5'd16:   c = -64'sd8756152;
      default: c = 64'sd0;
    endcase
    return (c + RomHalf) >>> RomShift;
  endfunction

endpackage

/* rtl/core/tkc_emf_if.sv */
// Handshake channel that carries one EMF sample per beat.
interface tkc_emf_if;
  import tkc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [EmfW-1:0] emf_mv_q16;

  modport source (output valid, output emf_mv_q16, input ready);
  modport sink (input valid, input emf_mv_q16, output ready);
endinterface

/* rtl/core/tkc_temp_if.sv */
// Handshake channel that carries one temperature result per beat.
interface tkc_temp_if;
  import tkc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [TempW-1:0] temp_c_q16;
  logic                    in_range;

  modport source (output valid, output temp_c_q16, output in_range, input ready);
  modport sink (input valid, input temp_c_q16, input in_range, output ready);
endinterface

/* rtl/core/thermocouple_k_emf_to_temperature_core.sv */
// Microcoded type K thermocouple EMF to temperature converter.
//
// An EMF beat (signed Q7.16 mV) enters on emf_i; one result beat leaves on temp_o
// with the temperature in degrees Celsius (signed Q.16) and an in-range flag.
// A six-step microprogram drives one Horner datapath: the step counter fetches a
// control word that selects the operation and a conditional jump. Each Horner
// step forms the two 32 by 23 bit partial products in the multiply step, then
// recombines them and adds the coefficient in the accumulate step; the loop sets the rate.
// The low band runs nine Horner steps, the high band six, and an out-of-range
// sample skips the loop and goes straight to the output step.
// A new beat is taken only once the block is back in its wait step, the cycle
// after the result is loaded into the output register, so a sample is finished
// before the next is taken; that next sample may be accepted while the previous
// result still waits in the output register.
// If the receiver stalls with a result still held, the block holds its finished
// result in the output step until the output register frees up.
// Reset clears the step counter and the output valid flag; the block keeps no
// state between samples.
module thermocouple_k_emf_to_temperature_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  tkc_emf_if.sink     emf_i,
  tkc_temp_if.source  temp_o
);
  import tkc_pkg::*;

  uword_t                  uword;
  step_t                   step_q, step_d;
  logic                    cond_hit;
  logic                    emf_accept;
  logic                    out_free;
  logic                    out_valid_q;
  logic signed [TempW-1:0] temp_q;
  logic                    range_out_q;

  logic [EmfW-1:0]         x_q;
  logic                    band_ok_q;
  logic                    band_ok_d;
  logic                    band_low_d;
  coef_addr_t              idx_q, base_q;
  logic signed [AccW-1:0]  acc_q;
  logic                    neg_q;
  logic [ProdW-1:0]        prod_hi_q, prod_lo_q;

  logic [AccW-1:0]         mag;
  logic [ProdW-1:0]        prod_hi_d, prod_lo_d;
  logic [AccW-1:0]         p_sum;
  logic signed [AccW-1:0]  p_mag;
  logic signed [AccW-1:0]  coef;
  logic signed [AccW-1:0]  mac;
  logic signed [AccW-1:0]  rsum;

  assign uword      = ucode(step_q);
  assign emf_accept = emf_i.valid && emf_i.ready;
  assign out_free   = !out_valid_q || temp_o.ready;

  always_comb begin
    case (uword.cond)
      CondIdle:     cond_hit = !emf_accept;
      CondOutRange: cond_hit = !band_ok_q;
      CondMore:     cond_hit = (idx_q != base_q);
      CondOutBusy:  cond_hit = !out_free;
      default:      cond_hit = 1'b0;
    endcase
    step_d = cond_hit ? uword.jump : uword.next;
  end

  assign emf_i.ready = (uword.op == OpWait);

  assign band_ok_d  = !emf_i.emf_mv_q16[EmfW-1] && (emf_i.emf_mv_q16 <= HighBandMax);
  assign band_low_d = (emf_i.emf_mv_q16 < HighBandStart);

  assign mag       = acc_q[AccW-1] ? (AccW'(0) - acc_q) : acc_q;
  assign prod_hi_d = ProdW'(mag[AccW-1:HalfW]) * ProdW'(x_q);
  assign prod_lo_d = ProdW'(mag[HalfW-1:0]) * ProdW'(x_q);
  assign p_sum     = {prod_hi_q[AccW-XFracBits-1:0], {XFracBits{1'b0}}}
                   + AccW'(prod_lo_q[ProdW-1:XFracBits]);
  assign p_mag     = {{(AccW-MagW){1'b0}}, p_sum[MagW-1:0]};
  assign coef      = coef_acc(idx_q);
  assign mac       = neg_q ? (coef - p_mag) : (coef + p_mag);
  assign rsum      = acc_q + OutHalf;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepWait;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (uword.op == OpOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (temp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (uword.op)
      OpWait: begin
        if (emf_accept) begin
          x_q       <= emf_i.emf_mv_q16;
          band_ok_q <= band_ok_d;
          idx_q     <= band_low_d ? LowTop : HighTop;
          base_q    <= band_low_d ? LowBase : HighBase;
        end
      end
      OpLoad: begin
        acc_q <= coef;
        idx_q <= idx_q - 5'd1;
      end
      OpMul: begin
        prod_hi_q <= prod_hi_d;
        prod_lo_q <= prod_lo_d;
        neg_q     <= acc_q[AccW-1];
      end
      OpMac: begin
        acc_q <= mac;
        if (idx_q != base_q) begin
          idx_q <= idx_q - 5'd1;
        end
      end
      OpOut: begin
        if (out_free) begin
          temp_q      <= band_ok_q ? rsum[OutShift +: TempW] : '0;
          range_out_q <= band_ok_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign temp_o.valid      = out_valid_q;
  assign temp_o.temp_c_q16 = temp_q;
  assign temp_o.in_range   = range_out_q;

endmodule

/* sim/thermocouple_k_emf_to_temperature_core_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the type K EMF to temperature converter core.
module thermocouple_k_emf_to_temperature_core_test;
  import tkc_pkg::*;

  typedef struct packed {
    logic signed [TempW-1:0] temp_c_q16;
    logic                    in_range;
  } temp_beat_t;

  logic clk_i;
  logic rst_ni;

  tkc_emf_if  emf_if ();
  tkc_temp_if temp_if ();

  thermocouple_k_emf_to_temperature_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .emf_i  (emf_if),
    .temp_o (temp_if)
  );

  temp_beat_t expected_temps[$];
  int         mismatch_count = 0;
  bit         src_idle = 1'b0;
  bit         sink_idle = 1'b0;
  bit         hold_request = 1'b0;
  int         hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("thermocouple_k_emf_to_temperature_core verification failed");
    $finish;
  end

  // ITS-90 inverse coefficients at 48 fractional bits.
  function automatic longint poly_coef(bit high_band, int idx);
    longint c;
    if (!high_band) begin
      case (idx)
        0:       c = 64'sd0;
        1:       c = 64'sd7060391652070575;
        2:       c = 64'sd22124231532933;
        3:       c = -64'sd70456873992872;
        4:       c = 64'sd23405404295928;
        5:       c = -64'sd3456608415499;
        6:       c = 64'sd275959080477;
        7:       c = -64'sd12421575165;
        8:       c = 64'sd297725653;
        default: c = -64'sd2963242;
      endcase
    end else begin
      case (idx)
        0:       c = -64'sd37100034485329383;
        1:       c = 64'sd13595866249572982;
        2:       c = -64'sd463316537390018;
        3:       c = 64'sd15381850309550;
        4:       c = -64'sd271643477987;
        5:       c = 64'sd2477597070;
        default: c = -64'sd8756152;
      endcase
    end
    return (c + (64'sd1 <<< (RomFracBits - AccFracBits - 1))) >>> (RomFracBits - AccFracBits);
  endfunction

  function automatic longint scale_by_emf(longint acc, longint unsigned x);
    bit                neg;
    longint unsigned   mag;
    longint unsigned   prod;
    neg  = acc < 0;
    mag  = neg ? 64'd0 - longint'(acc) : longint'(acc);
    prod = (((mag >> 32) * x) << 16) + (((mag & 64'hFFFF_FFFF) * x) >> 16);
    prod &= 64'h3FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic temp_beat_t convert_emf(logic signed [EmfW-1:0] emf);
    temp_beat_t r;
    longint     x;
    longint     acc;
    longint     t;
    bit         high_band;
    int         top;
    int         i;
    r = '0;
    x = emf;
    if (x < 0 || x > 3597926) return r;
    high_band = x >= 1352926;
    top = high_band ? 6 : 9;
    acc = poly_coef(high_band, top);
    for (i = top; i > 0; i--) begin
      acc = scale_by_emf(acc, longint'(x)) + poly_coef(high_band, i - 1);
    end
    t = (acc + (64'sd1 <<< (OutShift - 1))) >>> OutShift;
    r.temp_c_q16 = t[TempW-1:0];
    r.in_range = 1'b1;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && emf_if.valid && emf_if.ready) begin
      expected_temps.push_back(convert_emf(emf_if.emf_mv_q16));
    end
  end

  always @(posedge clk_i) begin
    temp_beat_t want;
    if (rst_ni && temp_if.valid && temp_if.ready) begin
      if (expected_temps.size() == 0) begin
        $error("unexpected result beat: temp_c_q16 %0d in_range %0b",
               temp_if.temp_c_q16, temp_if.in_range);
        mismatch_count++;
      end else begin
        want = expected_temps.pop_front();
        if (temp_if.temp_c_q16 !== want.temp_c_q16) begin
          $error("temp_c_q16 expected %0d actual %0d", want.temp_c_q16, temp_if.temp_c_q16);
          mismatch_count++;
        end
        if (temp_if.in_range !== want.in_range) begin
          $error("in_range expected %0b actual %0b", want.in_range, temp_if.in_range);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    temp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        temp_if.ready = 1'b0;
      end else begin
        temp_if.ready = !(sink_idle && $urandom_range(99) < 37);
      end
    end
  end

  task automatic send_emf(input logic signed [EmfW-1:0] emf);
    while (src_idle && $urandom_range(99) < 37) begin
      emf_if.valid = 1'b0;
      @(negedge clk_i);
    end
    emf_if.valid = 1'b1;
    emf_if.emf_mv_q16 = emf;
    do @(posedge clk_i); while (!emf_if.ready);
    @(negedge clk_i);
  endtask

  task automatic emf_quiet();
    emf_if.valid = 1'b0;
  endtask

  function automatic logic signed [EmfW-1:0] pick_emf();
    int r;
    r = $urandom_range(99);
    if (r < 40) return EmfW'($urandom_range(1352925, 0));
    if (r < 75) return EmfW'($urandom_range(3597926, 1352926));
    if (r < 80) return EmfW'(1352926 + $urandom_range(8) - 4);
    if (r < 85) return EmfW'(3597926 + $urandom_range(8) - 4);
    if (r < 88) return EmfW'($urandom_range(4) - 2);
    return EmfW'($urandom & 23'h7F_FFFF);
  endfunction

  task automatic test_band_edges();
    logic signed [EmfW-1:0] pts [21];
    int                     i;
    pts = '{23'sd0, 23'sd1, 23'sd65536, 23'sd655360, 23'sd1352924, 23'sd1352925,
            23'sd1352926, 23'sd1352927, 23'sd2621440, 23'sd3276800, 23'sd3597925,
            23'sd3597926, 23'sd3597927, 23'sd3932160, 23'sd4194303, -23'sd1,
            -23'sd65536, -23'sd3932160, -23'sd4194304, 23'sh2A_AAAA, 23'sh15_5555};
    src_idle = 1'b1;
    sink_idle = 1'b1;
    for (i = 0; i < 21; i++) send_emf(pts[i]);
    emf_quiet();
  endtask

  task automatic test_random_mix();
    int i;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    for (i = 0; i < 1280; i++) send_emf(pick_emf());
    emf_quiet();
  endtask

  task automatic test_steady_stream();
    int i;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    for (i = 0; i < 150; i++) send_emf(pick_emf());
    emf_quiet();
  endtask

  task automatic test_output_stall();
    int i;
    src_idle = 1'b0;
    sink_idle = 1'b1;
    hold_request = 1'b1;
    for (i = 0; i < 50; i++) send_emf(pick_emf());
    emf_quiet();
  endtask

  initial begin
    rst_ni = 1'b0;
    emf_if.valid = 1'b0;
    emf_if.emf_mv_q16 = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_band_edges();
    test_random_mix();
    test_steady_stream();
    test_output_stall();
    while (expected_temps.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && expected_temps.size() == 0) begin
      $display("thermocouple_k_emf_to_temperature_core verification clean");
    end else begin
      $display("thermocouple_k_emf_to_temperature_core verification failed");
    end
    $finish;
  end
endmodule
